// ----- design/npg_pkg.sv -----
`timescale 1ns / 1ps

package npg_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int NOTE_W          = 7;
  localparam int VEL_W           = 7;
  localparam int OP_W            = 2;
  localparam int GLIDE_W         = 23;
  localparam int COEFF_W         = 17;
  localparam int FRAC_W          = 16;
  localparam int PRI_W           = 2;
  localparam int CFG_IDX_W       = 2;
  localparam int IN_DATA_W       = 16;
  localparam int OUT_DATA_W      = 32;

  localparam logic [NOTE_W-1:0]  RESET_NOTE  = 7'd69;
  localparam logic [COEFF_W-1:0] COEFF_RESET = 17'h10000;

  // Input operation codes.
  localparam logic [OP_W-1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [OP_W-1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [OP_W-1:0] OP_ALL_OFF  = 2'd2;
  localparam logic [OP_W-1:0] OP_TICK     = 2'd3;

  // Priority modes; the unused code behaves as lowest note.
  localparam logic [PRI_W-1:0] PRI_LOW  = 2'd0;
  localparam logic [PRI_W-1:0] PRI_HIGH = 2'd1;
  localparam logic [PRI_W-1:0] PRI_LAST = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PRIORITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEGATO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RETRIG   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF    = 2'd3;

  typedef enum logic [1:0] {
    EV_ON,
    EV_OFF,
    EV_ALL,
    EV_TICK
  } ev_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_APPLY,
    ST_TOP,
    ST_PICK,
    ST_GLIDE,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_MATCH,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_TOP
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t         cmd;
    logic              s_en;
    logic              o_en;
    logic [NOTE_W-1:0] note;
  } cell_ctrl_t;

endpackage

// ----- design/npg_cell.sv -----
`timescale 1ns / 1ps

// One slot of both note stacks. Match and top-of-stack information ripples
// one cell per clock from the low end toward the high end.
module npg_cell import npg_pkg::*; #(
  parameter int IDX_W = 5,
  parameter int IDX   = 0
) (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [IDX_W-1:0]  s_count,
  input  logic [IDX_W-1:0]  o_count,
  input  logic [NOTE_W-1:0] s_left,
  input  logic              gt_left,
  input  logic              s_hit_left,
  input  logic              o_hit_left,
  input  logic [NOTE_W-1:0] s_top_left,
  input  logic [NOTE_W-1:0] o_top_left,
  input  logic [NOTE_W-1:0] s_right,
  input  logic [NOTE_W-1:0] o_right,
  output logic [NOTE_W-1:0] s_note,
  output logic [NOTE_W-1:0] o_note,
  output logic              gt,
  output logic              s_hit,
  output logic              o_hit,
  output logic [NOTE_W-1:0] s_top,
  output logic [NOTE_W-1:0] o_top
);

  localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(IDX);
  localparam logic [IDX_W-1:0] MY_NEXT = IDX_W'(IDX + 1);

  logic [NOTE_W-1:0] s_note_r, s_note_nxt, o_note_r, o_note_nxt;
  logic [NOTE_W-1:0] s_top_r, s_top_nxt, o_top_r, o_top_nxt;
  logic              s_hit_r, s_hit_nxt, o_hit_r, o_hit_nxt;
  logic              s_valid, o_valid, s_match, o_match;

  assign s_valid = (MY_IDX < s_count);
  assign o_valid = (MY_IDX < o_count);
  assign s_match = s_valid && (s_note_r == ctrl.note);
  assign o_match = o_valid && (o_note_r == ctrl.note);
  assign gt      = s_valid && (ctrl.note < s_note_r);

  always_comb begin
    s_note_nxt = s_note_r;
    o_note_nxt = o_note_r;
    s_hit_nxt  = s_hit_r;
    o_hit_nxt  = o_hit_r;
    s_top_nxt  = s_top_r;
    o_top_nxt  = o_top_r;
    unique case (ctrl.cmd)
      CELL_MATCH: begin
        // Prefix OR of matches: set from the first matching slot upward.
        s_hit_nxt = s_hit_left | s_match;
        o_hit_nxt = o_hit_left | o_match;
      end
      CELL_INSERT: begin
        if (ctrl.s_en) begin
          if (gt_left) begin
            s_note_nxt = s_left;
          end else if (gt || (MY_IDX == s_count)) begin
            s_note_nxt = ctrl.note;
          end
        end
        if (ctrl.o_en && (MY_IDX == o_count)) begin
          o_note_nxt = ctrl.note;
        end
      end
      CELL_REMOVE: begin
        if (s_hit_r) begin
          s_note_nxt = s_right;
        end
        if (o_hit_r) begin
          o_note_nxt = o_right;
        end
      end
      CELL_TOP: begin
        s_top_nxt = (MY_NEXT == s_count) ? s_note_r : s_top_left;
        o_top_nxt = (MY_NEXT == o_count) ? o_note_r : o_top_left;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    s_note_r <= s_note_nxt;
    o_note_r <= o_note_nxt;
    s_hit_r  <= s_hit_nxt;
    o_hit_r  <= o_hit_nxt;
    s_top_r  <= s_top_nxt;
    o_top_r  <= o_top_nxt;
  end

  assign s_note = s_note_r;
  assign o_note = o_note_r;
  assign s_hit  = s_hit_r;
  assign o_hit  = o_hit_r;
  assign s_top  = s_top_r;
  assign o_top  = o_top_r;

endmodule

// ----- design/npg_glide.sv -----
`timescale 1ns / 1ps

// One-pole glide in Q7.16: products are registered first, then summed and
// rounded into the value; coefficient bit 16 set makes it jump to the target.
module npg_glide import npg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [COEFF_W-1:0] coeff,
  input  logic [NOTE_W-1:0]  target,
  output logic [GLIDE_W-1:0] value,
  output logic               done
);

  localparam int P1_W  = FRAC_W + GLIDE_W;
  localparam int P2_W  = COEFF_W + NOTE_W;
  localparam int ACC_W = P1_W + 2;

  logic [GLIDE_W-1:0] value_r, value_nxt;
  logic               busy_r;
  logic               jump_r;
  logic [P1_W-1:0]    p1_r;
  logic [P2_W-1:0]    p2_r;
  logic [NOTE_W-1:0]  target_r;
  logic [COEFF_W-1:0] inv_coeff;
  logic [ACC_W-1:0]   acc;

  assign inv_coeff = COEFF_RESET - {1'b0, coeff[FRAC_W-1:0]};
  assign acc = ACC_W'(p1_r) + ACC_W'({p2_r, {FRAC_W{1'b0}}})
             + ACC_W'(1 << (FRAC_W - 1));

  always_comb begin
    value_nxt = value_r;
    if (busy_r) begin
      if (jump_r) begin
        value_nxt = {target_r, {FRAC_W{1'b0}}};
      end else begin
        value_nxt = acc[FRAC_W +: GLIDE_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      jump_r   <= coeff[FRAC_W];
      p1_r     <= P1_W'(coeff[FRAC_W-1:0]) * P1_W'(value_r);
      p2_r     <= P2_W'(inv_coeff) * P2_W'(target);
      target_r <= target;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      value_r <= {RESET_NOTE, {FRAC_W{1'b0}}};
    end else begin
      busy_r  <= start;
      value_r <= value_nxt;
    end
  end

  assign value = value_r;
  assign done  = busy_r;

endmodule

// ----- design/mono_note_priority_glide_top.sv -----
`timescale 1ns / 1ps

// Monophonic voice allocator with note priority and portamento.
// Input beats arrive on in_t*: in_tuser carries the operation (note on, note
// off, all notes off, sample tick) and in_tdata the note number and velocity.
// Every input beat yields exactly one output beat on out_t* carrying gate,
// trigger, target note and the glided pitch in Q7.16.
// Registers are written over cfg_* (always ready); the user must write them
// only while the block is idle, which the block itself does not enforce.
// A tick runs the glide unit; note on and note off make two passes along the
// cell chain (match search, then top-of-stack pickup), one cell per cycle. All
// notes off skips both. A duplicate note on finishes after the match pass.
// One item is processed at a time; in_tready is high only when idle.
// The result register lets the next item be accepted while a result waits;
// a stalled receiver holds that result and the following one waits to load.
// Synchronous reset clears both stacks, drops the gate, sets the chosen note
// to 69 and the glide to 69.0, and restores the register defaults.
module mono_note_priority_glide_top import npg_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // note_number[6:0], velocity[13:7]
  input  logic [OP_W-1:0]       in_tuser,   // operation[1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // gate[0], trigger[1],
                                            // target_note[8:2], glide_note[31:9]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COEFF_W-1:0]    cfg_data
);

  localparam int IDX_W = $clog2(STACK_DEPTH + 1);
  localparam logic [IDX_W-1:0] DEPTH_CNT = IDX_W'(STACK_DEPTH);
  localparam logic [IDX_W-1:0] LAST_CNT  = IDX_W'(STACK_DEPTH - 1);

  // Configuration registers.
  logic [PRI_W-1:0]   pri_mode_r;
  logic               legato_r;
  logic               retrig_r;
  logic [COEFF_W-1:0] coeff_r;

  state_t             state_r, state_nxt;
  ev_kind_t           kind_r, kind_nxt, kind_in;
  logic [NOTE_W-1:0]  note_r, note_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   s_count_r, s_count_nxt, o_count_r, o_count_nxt;
  logic [NOTE_W-1:0]  chosen_r, chosen_nxt;
  logic               gate_r, gate_nxt;
  logic               pend_r, pend_nxt;
  logic               trig_r, trig_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  cell_ctrl_t         ctrl;
  logic               glide_start, glide_done;
  logic [GLIDE_W-1:0] glide_value;

  logic [NOTE_W-1:0]  s_note [STACK_DEPTH];
  logic [NOTE_W-1:0]  o_note [STACK_DEPTH];
  logic [NOTE_W-1:0]  s_top  [STACK_DEPTH];
  logic [NOTE_W-1:0]  o_top  [STACK_DEPTH];
  logic               gt     [STACK_DEPTH];
  logic               s_hit  [STACK_DEPTH];
  logic               o_hit  [STACK_DEPTH];

  logic [OP_W-1:0]    in_op;
  logic [NOTE_W-1:0]  in_note;
  logic [VEL_W-1:0]   in_vel;

  assign in_op   = in_tuser;
  assign in_note = in_tdata[NOTE_W-1:0];
  assign in_vel  = in_tdata[NOTE_W +: VEL_W];

  // A note on with zero velocity is handled as a note off.
  always_comb begin
    unique case (in_op)
      OP_NOTE_ON:  kind_in = (in_vel == '0) ? EV_OFF : EV_ON;
      OP_NOTE_OFF: kind_in = EV_OFF;
      OP_ALL_OFF:  kind_in = EV_ALL;
      OP_TICK:     kind_in = EV_TICK;
      default:     kind_in = EV_TICK;
    endcase
  end

  // Configuration port: always ready, writes beyond the list are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pri_mode_r <= PRI_LOW;
      legato_r   <= 1'b0;
      retrig_r   <= 1'b0;
      coeff_r    <= COEFF_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PRIORITY: pri_mode_r <= cfg_data[PRI_W-1:0];
        REG_LEGATO:   legato_r   <= cfg_data[0];
        REG_RETRIG:   retrig_r   <= cfg_data[0];
        REG_COEFF:    coeff_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The cell chain. Cell 0 sees zeros on its low side; the last cell sees
  // its own contents on its high side, which only matters past the count.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [NOTE_W-1:0] s_lt, s_tl, o_tl, s_rt, o_rt;
    logic              g_lt, sh_lt, oh_lt;

    if (i == 0) begin : g_first
      assign s_lt  = '0;
      assign g_lt  = 1'b0;
      assign sh_lt = 1'b0;
      assign oh_lt = 1'b0;
      assign s_tl  = '0;
      assign o_tl  = '0;
    end else begin : g_mid
      assign s_lt  = s_note[i-1];
      assign g_lt  = gt[i-1];
      assign sh_lt = s_hit[i-1];
      assign oh_lt = o_hit[i-1];
      assign s_tl  = s_top[i-1];
      assign o_tl  = o_top[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign s_rt = s_note[i];
      assign o_rt = o_note[i];
    end else begin : g_inner
      assign s_rt = s_note[i+1];
      assign o_rt = o_note[i+1];
    end

    npg_cell #(
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .s_count    (s_count_r),
      .o_count    (o_count_r),
      .s_left     (s_lt),
      .gt_left    (g_lt),
      .s_hit_left (sh_lt),
      .o_hit_left (oh_lt),
      .s_top_left (s_tl),
      .o_top_left (o_tl),
      .s_right    (s_rt),
      .o_right    (o_rt),
      .s_note     (s_note[i]),
      .o_note     (o_note[i]),
      .gt         (gt[i]),
      .s_hit      (s_hit[i]),
      .o_hit      (o_hit[i]),
      .s_top      (s_top[i]),
      .o_top      (o_top[i])
    );
  end

  npg_glide u_glide (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (glide_start),
    .coeff  (coeff_r),
    .target (chosen_r),
    .value  (glide_value),
    .done   (glide_done)
  );

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    note_nxt      = note_r;
    cnt_nxt       = cnt_r;
    s_count_nxt   = s_count_r;
    o_count_nxt   = o_count_r;
    chosen_nxt    = chosen_r;
    gate_nxt      = gate_r;
    pend_nxt      = pend_r;
    trig_nxt      = trig_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    glide_start   = 1'b0;
    ctrl          = '{cmd: CELL_HOLD, s_en: 1'b0, o_en: 1'b0, note: note_r};

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          kind_nxt = kind_in;
          note_nxt = in_note;
          trig_nxt = 1'b0;
          cnt_nxt  = '0;
          unique case (kind_in)
            EV_ON, EV_OFF: begin
              state_nxt = ST_MATCH;
            end
            EV_ALL: begin
              s_count_nxt = '0;
              o_count_nxt = '0;
              gate_nxt    = 1'b0;
              pend_nxt    = 1'b0;
              state_nxt   = ST_OUT;
            end
            default: begin
              glide_start = 1'b1;
              trig_nxt    = pend_r;
              pend_nxt    = 1'b0;
              state_nxt   = ST_GLIDE;
            end
          endcase
        end
      end
      ST_MATCH: begin
        ctrl.cmd = CELL_MATCH;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == LAST_CNT) begin
          cnt_nxt   = '0;
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (kind_r == EV_ON) begin
          if (s_hit[STACK_DEPTH-1]) begin
            // Note already held: nothing changes.
            state_nxt = ST_OUT;
          end else begin
            ctrl.cmd  = CELL_INSERT;
            ctrl.s_en = (s_count_r < DEPTH_CNT);
            ctrl.o_en = (o_count_r < DEPTH_CNT);
            if (ctrl.s_en) begin
              s_count_nxt = s_count_r + 1'b1;
            end
            if (ctrl.o_en) begin
              o_count_nxt = o_count_r + 1'b1;
            end
            state_nxt = ST_TOP;
          end
        end else begin
          ctrl.cmd = CELL_REMOVE;
          if (s_hit[STACK_DEPTH-1]) begin
            s_count_nxt = s_count_r - 1'b1;
          end
          if (o_hit[STACK_DEPTH-1]) begin
            o_count_nxt = o_count_r - 1'b1;
          end
          state_nxt = ST_TOP;
        end
      end
      ST_TOP: begin
        ctrl.cmd = CELL_TOP;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == LAST_CNT) begin
          cnt_nxt   = '0;
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        if (s_count_r == '0) begin
          gate_nxt = 1'b0;
        end else begin
          gate_nxt = 1'b1;
          unique case (pri_mode_r)
            PRI_HIGH: chosen_nxt = s_top[STACK_DEPTH-1];
            PRI_LAST: chosen_nxt = (o_count_r != '0) ? o_top[STACK_DEPTH-1] : s_note[0];
            default:  chosen_nxt = s_note[0];
          endcase
        end
        if (kind_r == EV_ON) begin
          // gate_r still holds the gate from before this note on.
          if (!legato_r || !gate_r || retrig_r) begin
            pend_nxt = 1'b1;
          end
        end else begin
          pend_nxt = 1'b0;
        end
        state_nxt = ST_OUT;
      end
      ST_GLIDE: begin
        if (glide_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {glide_value, chosen_r, trig_r, gate_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s_count_r   <= '0;
      o_count_r   <= '0;
      chosen_r    <= RESET_NOTE;
      gate_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      s_count_r   <= s_count_nxt;
      o_count_r   <= o_count_nxt;
      chosen_r    <= chosen_nxt;
      gate_r      <= gate_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    note_r     <= note_nxt;
    trig_r     <= trig_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Both stacks always hold the same set of notes, so their fill counts agree.
  a_counts_equal : assert property (@(posedge clk) disable iff (!rst_n)
    s_count_r == o_count_r)
    else $error("note stack counts diverged");

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    s_count_r <= DEPTH_CNT)
    else $error("note stack count above depth");

  // Between items the gate reflects whether any note is held.
  a_gate_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (gate_r == (s_count_r != '0)))
    else $error("gate out of step with held notes");

  // The glide unit only runs while a tick is being processed.
  a_glide_owner : assert property (@(posedge clk) disable iff (!rst_n)
    glide_done |-> (state_r == ST_GLIDE) && (kind_r == EV_TICK))
    else $error("glide update outside a tick");

endmodule
